// ===== hw/rtl/lrms_pkg.sv =====
// Shared types, codes and reset constants for the line robot mission sequencer.
// Used by every module of the block; depends on nothing.
package lrms_pkg;

    typedef enum logic [2:0] {
        MODE_INIT   = 3'd0,
        MODE_WAIT   = 3'd1,
        MODE_CHECK  = 3'd2,
        MODE_AVOID  = 3'd3,
        MODE_FOLLOW = 3'd4,
        MODE_STOP   = 3'd5,
        MODE_CELEB  = 3'd6
    } t_mode;

    typedef enum logic [2:0] {
        CMD_HOLD  = 3'd0,
        CMD_STOP  = 3'd1,
        CMD_FWD   = 3'd2,
        CMD_LEFT  = 3'd3,
        CMD_RIGHT = 3'd4
    } t_cmd;

    // configuration register indexes
    localparam logic [2:0] CFG_START_DELAY = 3'd0;
    localparam logic [2:0] CFG_STOP_TIME   = 3'd1;
    localparam logic [2:0] CFG_EDGE_TIME   = 3'd2;
    localparam logic [2:0] CFG_OBST_DIST   = 3'd3;
    localparam logic [2:0] CFG_CELEB_DELAY = 3'd4;
    localparam logic [2:0] CFG_CELEB_ANGLE = 3'd5;

    localparam logic [19:0] RST_START_DELAY = 20'd0;
    localparam logic [19:0] RST_STOP_TIME   = 20'd100000;
    localparam logic [19:0] RST_EDGE_TIME   = 20'd10000;
    localparam logic [9:0]  RST_OBST_DIST   = 10'd10;
    localparam logic [15:0] RST_CELEB_DELAY = 16'd500;
    localparam logic [6:0]  RST_CELEB_ANGLE = 7'd45;

    localparam logic [7:0]  SERVO_CENTRE    = 8'd90;
    localparam logic [6:0]  ANGLE_MAX       = 7'd90;

    localparam int unsigned IN_TDATA_W  = 56;
    localparam int unsigned OUT_TDATA_W = 24;

    typedef struct packed {
        logic [19:0] start_delay_ms;
        logic [19:0] stop_time_ms;
        logic [19:0] edge_stop_time_ms;
        logic [9:0]  obstacle_distance_cm;
        logic [15:0] celebration_delay_ms;
        logic [6:0]  celebration_angle;
    } t_cfg;

    typedef struct packed {
        logic        line_right_black;
        logic        line_left_black;
        logic [9:0]  dist_right_cm;
        logic [9:0]  dist_left_cm;
        logic        start_pulled;
        logic [31:0] now_ms;
    } t_item;

    typedef struct packed {
        logic        waiting_lamp;
        t_mode       mission_state;
        logic [7:0]  servo_deg;
        logic        led_on;
        logic        slow_turn;
        t_cmd        motor_cmd;
    } t_res;

endpackage

// ===== hw/rtl/line_robot_mission_sequencer_unit.sv =====
// Top level of the line robot mission sequencer: stream ports, input and result registers.
// Depends on lrms_pkg, lrms_cfg and lrms_core.
//
//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+-------------------------------
//  s_axis    | in        | s_axis_tvalid / s_axis_tready| one tick of sensor readings
//  m_axis    | out       | m_axis_tvalid / m_axis_tready| one result per tick
//  cfg       | in        | i_cfg_valid / o_cfg_ready    | register index and write data
//
// One tick per clock cycle sustained while m_axis does not stall; a result passes the input
// register, then the mission logic into the result register, before it is offered.
// The mission state advances only when a registered tick moves into the result register,
// so a stall on m_axis holds both stages and back-pressures s_axis; no tick is lost.
// Reset is synchronous, active low: state goes to init, registers to their defaults.
// Configuration writes are always taken (o_cfg_ready stays high out of reset).
module line_robot_mission_sequencer_unit import lrms_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // tick in
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [31:0] now_ms, [32] start_pulled, [42:33] dist_left_cm, [52:43] dist_right_cm,
    // [53] line_left_black, [54] line_right_black, [55] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // result out
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [2:0] motor_cmd, [3] slow_turn, [4] led_on, [12:5] servo_deg,
    // [15:13] mission_state, [16] waiting_lamp, [23:17] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [2:0]             i_cfg_index,
    input  logic [19:0]            i_cfg_data
);

    logic  r_in_valid;
    t_item r_in;
    logic  r_out_valid;
    t_res  r_out;
    logic  r_cfg_ready;

    logic  w_advance;
    logic  w_in_xfer;
    t_cfg  w_cfg;
    t_res  w_res;

    // the result stage frees up when empty or when its transfer completes
    assign w_advance     = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cfg_ready <= 1'b0;
        end else begin
            r_cfg_ready <= 1'b1;
            if (w_in_xfer)      r_in_valid <= 1'b1;
            else if (w_advance) r_in_valid <= 1'b0;
            if (w_advance)      r_out_valid <= r_in_valid;
        end
    end

    // payload registers: no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_xfer)               r_in  <= s_axis_tdata[$bits(t_item)-1:0];
        if (w_advance && r_in_valid) r_out <= w_res;
    end

    lrms_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && r_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    lrms_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_advance && r_in_valid),
        .i_item  (r_in),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    assign o_cfg_ready   = r_cfg_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - $bits(t_res)){1'b0}}, r_out};

endmodule

// ===== hw/rtl/lrms_cfg.sv =====
// Configuration register file of the mission sequencer.
// Depends on lrms_pkg for register indexes, reset values and t_cfg.
module lrms_cfg import lrms_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr,
    input  logic [2:0]  i_index,
    input  logic [19:0] i_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_delay_ms       <= RST_START_DELAY;
            r_cfg.stop_time_ms         <= RST_STOP_TIME;
            r_cfg.edge_stop_time_ms    <= RST_EDGE_TIME;
            r_cfg.obstacle_distance_cm <= RST_OBST_DIST;
            r_cfg.celebration_delay_ms <= RST_CELEB_DELAY;
            r_cfg.celebration_angle    <= RST_CELEB_ANGLE;
        end else if (i_wr) begin
            unique case (i_index)
                CFG_START_DELAY: r_cfg.start_delay_ms       <= i_data;
                CFG_STOP_TIME:   r_cfg.stop_time_ms         <= i_data;
                CFG_EDGE_TIME:   r_cfg.edge_stop_time_ms    <= i_data;
                CFG_OBST_DIST:   r_cfg.obstacle_distance_cm <= i_data[9:0];
                CFG_CELEB_DELAY: r_cfg.celebration_delay_ms <= i_data[15:0];
                CFG_CELEB_ANGLE: r_cfg.celebration_angle    <= i_data[6:0];
                default: ; // unknown index: drop the write
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/lrms_core.sv =====
// Mission state machine and timing datapath: one tick handled per step.
// Depends on lrms_pkg for t_mode, t_cmd, t_cfg, t_item and t_res.
module lrms_core import lrms_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_step,
    input  t_item i_item,
    input  t_cfg  i_cfg,
    output t_res  o_res
);

    t_mode       r_mode, n_mode;
    t_mode       r_prior, n_prior;
    logic [31:0] r_stamp, n_stamp;
    logic        r_started, n_started;
    logic [31:0] r_obs_begin, n_obs_begin;
    logic [31:0] r_obs_total, n_obs_total;
    logic [31:0] r_last_swing, n_last_swing;
    logic        r_swing_neg, n_swing_neg;
    logic        r_led, n_led;
    logic        r_slow, n_slow;
    logic [7:0]  r_servo, n_servo;

    logic [31:0] w_elapsed;
    t_mode       w_mode;
    logic        w_obstacle;
    logic [31:0] w_follow_t;
    logic        w_edge_hit;
    logic [24:0] w_t20;
    logic [24:0] w_edge9;
    logic        w_swing_due;
    logic [6:0]  w_angle;
    t_cmd        w_cmd;
    logic        w_lamp;

    assign w_elapsed  = r_started ? (i_item.now_ms - r_stamp) : i_item.now_ms;
    // global stop overrides every mode but celebrate
    assign w_mode     = (w_elapsed >= {12'd0, i_cfg.stop_time_ms} && r_mode != MODE_CELEB)
                      ? MODE_STOP : r_mode;
    assign w_obstacle = (i_item.dist_left_cm  < i_cfg.obstacle_distance_cm) ||
                        (i_item.dist_right_cm < i_cfg.obstacle_distance_cm);
    assign w_follow_t = w_elapsed - {12'd0, i_cfg.start_delay_ms} - r_obs_total;
    assign w_edge_hit = w_follow_t >= {12'd0, i_cfg.edge_stop_time_ms};
    // below the edge time t fits in 20 bits, so the 0.45 compare stays narrow
    assign w_t20      = {1'b0, w_follow_t[19:0], 4'd0} + {3'd0, w_follow_t[19:0], 2'd0};
    assign w_edge9    = {2'd0, i_cfg.edge_stop_time_ms, 3'd0} +
                        {5'd0, i_cfg.edge_stop_time_ms};
    assign w_swing_due = (w_elapsed - r_last_swing) >= {16'd0, i_cfg.celebration_delay_ms};
    assign w_angle    = (i_cfg.celebration_angle > ANGLE_MAX) ? ANGLE_MAX
                                                              : i_cfg.celebration_angle;

    // next state
    always_comb begin
        n_mode  = w_mode;
        n_prior = r_prior;
        unique case (w_mode)
            MODE_INIT: begin
                if (i_item.start_pulled) n_mode = MODE_WAIT;
            end
            MODE_WAIT: begin
                if (w_elapsed >= {12'd0, i_cfg.start_delay_ms}) begin
                    n_prior = MODE_WAIT;
                    n_mode  = MODE_CHECK;
                end
            end
            MODE_CHECK: begin
                n_prior = MODE_CHECK;
                n_mode  = w_obstacle ? MODE_AVOID : MODE_FOLLOW;
            end
            MODE_AVOID: begin
                n_prior = MODE_AVOID;
                n_mode  = MODE_CHECK;
            end
            MODE_FOLLOW: begin
                n_prior = MODE_FOLLOW;
                n_mode  = w_edge_hit ? MODE_STOP : MODE_CHECK;
            end
            MODE_STOP:  n_mode = MODE_CELEB;
            MODE_CELEB: n_mode = MODE_CELEB;
            default:    n_mode = MODE_STOP;
        endcase
    end

    // outputs and datapath updates
    always_comb begin
        w_cmd        = CMD_HOLD;
        w_lamp       = 1'b0;
        n_stamp      = r_stamp;
        n_started    = r_started;
        n_obs_begin  = r_obs_begin;
        n_obs_total  = r_obs_total;
        n_last_swing = r_last_swing;
        n_swing_neg  = r_swing_neg;
        n_led        = r_led;
        n_slow       = r_slow;
        n_servo      = r_servo;
        unique case (w_mode)
            MODE_INIT: begin
                if (i_item.start_pulled) begin
                    n_stamp   = i_item.now_ms;
                    n_started = 1'b1;
                end else begin
                    w_lamp = 1'b1;
                end
            end
            MODE_WAIT: ;
            MODE_CHECK: begin
                if (w_obstacle) begin
                    if (r_prior != MODE_AVOID) n_obs_begin = w_elapsed;
                end else if (r_prior == MODE_AVOID) begin
                    n_obs_total = r_obs_total + (w_elapsed - r_obs_begin);
                end
            end
            MODE_AVOID: w_cmd = CMD_STOP;
            MODE_FOLLOW: begin
                if (!w_edge_hit) begin
                    if (w_t20 >= w_edge9) n_slow = 1'b1;
                    if (!i_item.line_left_black && i_item.line_right_black)
                        w_cmd = CMD_LEFT;
                    else if (i_item.line_left_black && !i_item.line_right_black)
                        w_cmd = CMD_RIGHT;
                    else
                        w_cmd = CMD_FWD;
                end
            end
            MODE_STOP: w_cmd = CMD_STOP;
            MODE_CELEB: begin
                if (w_swing_due) begin
                    n_led        = !r_led;
                    n_servo      = r_swing_neg ? (SERVO_CENTRE - {1'b0, w_angle})
                                               : (SERVO_CENTRE + {1'b0, w_angle});
                    n_swing_neg  = !r_swing_neg;
                    n_last_swing = w_elapsed;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_INIT;
            r_prior      <= MODE_INIT;
            r_stamp      <= '0;
            r_started    <= 1'b0;
            r_obs_begin  <= '0;
            r_obs_total  <= '0;
            r_last_swing <= '0;
            r_swing_neg  <= 1'b0;
            r_led        <= 1'b0;
            r_slow       <= 1'b0;
            r_servo      <= SERVO_CENTRE;
        end else if (i_step) begin
            r_mode       <= n_mode;
            r_prior      <= n_prior;
            r_stamp      <= n_stamp;
            r_started    <= n_started;
            r_obs_begin  <= n_obs_begin;
            r_obs_total  <= n_obs_total;
            r_last_swing <= n_last_swing;
            r_swing_neg  <= n_swing_neg;
            r_led        <= n_led;
            r_slow       <= n_slow;
            r_servo      <= n_servo;
        end
    end

    assign o_res.motor_cmd     = w_cmd;
    assign o_res.slow_turn     = n_slow;
    assign o_res.led_on        = n_led;
    assign o_res.servo_deg     = n_servo;
    assign o_res.mission_state = n_mode;
    assign o_res.waiting_lamp  = w_lamp;

endmodule

// ===== hw/rtl/lrms_chk.sv =====
// Port-level checker for the mission sequencer, bound to the top level.
// Depends on lrms_pkg for the motor and mission codes.
module lrms_chk import lrms_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [2:0] w_cmd;
    logic [2:0] w_state;
    logic       w_lamp;

    assign w_cmd   = m_axis_tdata[2:0];
    assign w_state = m_axis_tdata[15:13];
    assign w_lamp  = m_axis_tdata[16];

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // the lamp only lights on a tick that stays in init
    a_lamp_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_lamp |-> w_state == MODE_INIT)
        else $error("waiting lamp outside init");

    // a stop command leads back to check (after avoid) or into celebrate
    a_stop_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_cmd == CMD_STOP |-> w_state == MODE_CHECK || w_state == MODE_CELEB)
        else $error("stop command with wrong next state");

    // a steering command always returns to check
    a_steer_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_cmd == CMD_FWD || w_cmd == CMD_LEFT || w_cmd == CMD_RIGHT)
        |-> w_state == MODE_CHECK)
        else $error("steering command with wrong next state");

endmodule

bind line_robot_mission_sequencer_unit lrms_chk u_lrms_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/mission_check_pkg.sv =====
// Mission tracker for the line robot sequencer testbench: mirrors the sequencer
// state and registers, predicts every result transfer and checks the ones received.
// Depends on lrms_pkg for the mode, command, register and payload types.
package mission_check_pkg;
    timeunit 1ns;
    timeprecision 1ps;

    import lrms_pkg::*;

    class mission_tracker;
        t_cfg        cfg;
        t_mode       mode;
        t_mode       prior_mode;
        logic [31:0] start_stamp;
        logic [31:0] obstacle_begin;
        logic [31:0] obstacle_total;
        logic [31:0] last_swing;
        bit          started;
        bit          swing_negative;
        bit          led_level;
        bit          slow_flag;
        logic [7:0]  servo_pos;
        t_res        due_reports[$];
        int unsigned mismatches;

        function new();
            cfg.start_delay_ms       = RST_START_DELAY;
            cfg.stop_time_ms         = RST_STOP_TIME;
            cfg.edge_stop_time_ms    = RST_EDGE_TIME;
            cfg.obstacle_distance_cm = RST_OBST_DIST;
            cfg.celebration_delay_ms = RST_CELEB_DELAY;
            cfg.celebration_angle    = RST_CELEB_ANGLE;
            mode           = MODE_INIT;
            prior_mode     = MODE_INIT;
            start_stamp    = '0;
            obstacle_begin = '0;
            obstacle_total = '0;
            last_swing     = '0;
            started        = 1'b0;
            swing_negative = 1'b0;
            led_level      = 1'b0;
            slow_flag      = 1'b0;
            servo_pos      = SERVO_CENTRE;
            mismatches     = 0;
        endfunction

        // narrow registers keep only their low bits; spare indexes are dropped
        function void set_reg(logic [2:0] index, logic [19:0] data);
            case (index)
                CFG_START_DELAY: cfg.start_delay_ms       = data;
                CFG_STOP_TIME:   cfg.stop_time_ms         = data;
                CFG_EDGE_TIME:   cfg.edge_stop_time_ms    = data;
                CFG_OBST_DIST:   cfg.obstacle_distance_cm = data[9:0];
                CFG_CELEB_DELAY: cfg.celebration_delay_ms = data[15:0];
                CFG_CELEB_ANGLE: cfg.celebration_angle    = data[6:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return due_reports.size();
        endfunction

        // advance the mission by one accepted tick and queue the result it causes
        function void note_tick(t_item reading);
            t_res        report;
            t_cmd        cmd;
            logic [31:0] elapsed;
            logic [31:0] follow_ms;
            logic [6:0]  swing;
            bit          lamp;

            cmd  = CMD_HOLD;
            lamp = 1'b0;
            elapsed = started ? reading.now_ms - start_stamp : reading.now_ms;

            if (elapsed >= 32'(cfg.stop_time_ms) && mode != MODE_CELEB)
                mode = MODE_STOP;

            case (mode)
                MODE_INIT: begin
                    if (reading.start_pulled) begin
                        start_stamp = reading.now_ms;
                        started     = 1'b1;
                        mode        = MODE_WAIT;
                    end else begin
                        lamp = 1'b1;
                    end
                end
                MODE_WAIT: begin
                    if (elapsed >= 32'(cfg.start_delay_ms)) begin
                        prior_mode = MODE_WAIT;
                        mode       = MODE_CHECK;
                    end
                end
                MODE_CHECK: begin
                    if (reading.dist_left_cm < cfg.obstacle_distance_cm ||
                        reading.dist_right_cm < cfg.obstacle_distance_cm) begin
                        if (prior_mode != MODE_AVOID)
                            obstacle_begin = elapsed;
                        mode = MODE_AVOID;
                    end else begin
                        if (prior_mode == MODE_AVOID)
                            obstacle_total = obstacle_total + (elapsed - obstacle_begin);
                        mode = MODE_FOLLOW;
                    end
                    prior_mode = MODE_CHECK;
                end
                MODE_AVOID: begin
                    cmd        = CMD_STOP;
                    prior_mode = MODE_AVOID;
                    mode       = MODE_CHECK;
                end
                MODE_FOLLOW: begin
                    // an early clock wraps the follow time high and ends the run
                    follow_ms = elapsed - 32'(cfg.start_delay_ms) - obstacle_total;
                    if (follow_ms >= 32'(cfg.edge_stop_time_ms)) begin
                        prior_mode = MODE_FOLLOW;
                        mode       = MODE_STOP;
                    end else begin
                        if (64'(follow_ms) * 64'd20 >= 64'(cfg.edge_stop_time_ms) * 64'd9)
                            slow_flag = 1'b1;
                        if (!reading.line_left_black && reading.line_right_black)
                            cmd = CMD_LEFT;
                        else if (reading.line_left_black && !reading.line_right_black)
                            cmd = CMD_RIGHT;
                        else
                            cmd = CMD_FWD;
                        prior_mode = MODE_FOLLOW;
                        mode       = MODE_CHECK;
                    end
                end
                MODE_STOP: begin
                    cmd  = CMD_STOP;
                    mode = MODE_CELEB;
                end
                MODE_CELEB: begin
                    if (elapsed - last_swing >= 32'(cfg.celebration_delay_ms)) begin
                        swing = (cfg.celebration_angle > ANGLE_MAX) ? ANGLE_MAX
                                                                    : cfg.celebration_angle;
                        led_level = !led_level;
                        servo_pos = swing_negative ? SERVO_CENTRE - 8'(swing)
                                                   : SERVO_CENTRE + 8'(swing);
                        swing_negative = !swing_negative;
                        last_swing     = elapsed;
                    end
                end
                default: mode = MODE_STOP;
            endcase

            report               = '0;
            report.motor_cmd     = cmd;
            report.slow_turn     = slow_flag;
            report.led_on        = led_level;
            report.servo_deg     = servo_pos;
            report.mission_state = mode;
            report.waiting_lamp  = lamp;
            due_reports.push_back(report);
        endfunction

        function void match_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_report(t_res got);
            t_res want;
            if (due_reports.size() == 0) begin
                $display("%0t: result %h arrived with none expected", $time, got);
                mismatches++;
                return;
            end
            want = due_reports.pop_front();
            match_field("motor_cmd", want.motor_cmd, got.motor_cmd);
            match_field("slow_turn", want.slow_turn, got.slow_turn);
            match_field("led_on", want.led_on, got.led_on);
            match_field("servo_deg", want.servo_deg, got.servo_deg);
            match_field("mission_state", want.mission_state, got.mission_state);
            match_field("waiting_lamp", want.waiting_lamp, got.waiting_lamp);
        endfunction
    endclass

endpackage

// ===== tb/tb_top.sv =====
// Testbench top for line_robot_mission_sequencer_unit: drives sensor ticks and register
// writes, predicts every result with mission_tracker and checks each one as it arrives.
// Depends on lrms_pkg, mission_check_pkg and the sequencer RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lrms_pkg::*;
    import mission_check_pkg::*;

    localparam int          CLK_HALF      = 10;
    localparam int          RESET_CYCLES  = 8;
    localparam int          SETTLE_CYCLES = 4;       // result lags its tick through the input and result registers
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam logic [31:0] PULL_STAMP    = 32'd1000;
    localparam logic [19:0] TIME_MAX      = 20'hFFFFF;
    localparam logic [9:0]  DIST_MAX      = 10'h3FF;
    // register indexes beyond the six defined ones
    localparam logic [2:0]  CFG_SPARE_LO  = CFG_CELEB_ANGLE + 3'd1;
    localparam logic [2:0]  CFG_SPARE_HI  = CFG_CELEB_ANGLE + 3'd2;

    // how the mission is brought to its stop
    typedef enum int {END_EDGE, END_EARLY, END_GLOBAL} t_ending;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [2:0]             i_cfg_index   = CFG_START_DELAY;
    logic [19:0]            i_cfg_data    = '0;

    mission_tracker tracker;
    int unsigned    send_idle_pct = 0;
    int unsigned    recv_idle_pct = 0;
    int unsigned    cycle_count   = 0;
    logic [31:0]    mission_ms    = '0;   // clock value carried by the latest tick

    line_robot_mission_sequencer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Receiver: drop tready at random at the falling edge, at the rate of the current phase.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Observe every transfer at the rising edge. Register writes and ticks update the
    // tracker the moment they are taken; results are checked in arrival order.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_report(t_res'(m_axis_tdata[$bits(t_res)-1:0]));
            if (s_axis_tvalid && s_axis_tready)
                tracker.note_tick(t_item'(s_axis_tdata[$bits(t_item)-1:0]));
            if (i_cfg_valid && o_cfg_ready)
                tracker.set_reg(i_cfg_index, i_cfg_data);
        end
    end

    // Watchdog: end the run if it overruns a generous cycle budget.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_top: errors");
        $finish;
    end

    function automatic t_item make_tick(logic [31:0] now, logic pulled, logic [9:0] dl,
                                        logic [9:0] dr, logic lb, logic rb);
        t_item reading;
        reading.now_ms           = now;
        reading.start_pulled     = pulled;
        reading.dist_left_cm     = dl;
        reading.dist_right_cm    = dr;
        reading.line_left_black  = lb;
        reading.line_right_black = rb;
        return reading;
    endfunction

    // Offer one tick and hold it until the transfer happens. Called and left at a falling
    // edge; tvalid stays high afterwards so that back-to-back ticks need not lower it in between.
    task automatic send_tick(input t_item reading);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - $bits(t_item)){1'b0}}, reading};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // One register write transfer; lower valid only after the last write of a burst.
    task automatic write_reg(input logic [2:0] index, input logic [19:0] data, input bit last);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        if (last)
            i_cfg_valid <= 1'b0;
    endtask

    // Stop offering ticks, wait for every predicted result, then let the pipe settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // A well-formed tick for the state the mission is in. The clock advances by a few
    // milliseconds but never far enough to reach the edge or the global stop time, so the
    // mission keeps cycling between check, avoid and follow. In check most ticks are a
    // clear road or an obstacle on one or both sides; the rest are plain noise.
    task automatic mission_tick();
        logic [31:0] elapsed;
        logic [31:0] follow_ms;
        logic [31:0] room;
        logic [31:0] stop_room;
        logic [9:0]  dl;
        logic [9:0]  dr;
        logic [9:0]  near;
        int unsigned roll;
        int unsigned side;
        int unsigned adv;

        elapsed   = mission_ms - tracker.start_stamp;
        follow_ms = elapsed - 32'(tracker.cfg.start_delay_ms) - tracker.obstacle_total;
        room      = 32'(tracker.cfg.edge_stop_time_ms) - 32'd1 - follow_ms;
        stop_room = 32'(tracker.cfg.stop_time_ms) - 32'd1 - elapsed;
        if (stop_room < room)
            room = stop_room;
        adv = $urandom_range(3);
        if (adv > room)
            adv = room;

        dl = 10'($urandom);
        dr = 10'($urandom);
        if (tracker.mode == MODE_CHECK) begin
            roll = $urandom_range(99);
            if (roll >= 10) begin
                if (roll < 40 && tracker.cfg.obstacle_distance_cm != '0) begin
                    near = 10'($urandom_range(32'(tracker.cfg.obstacle_distance_cm) - 1));
                    side = $urandom_range(2);
                    if (side == 0) begin
                        dl = near;
                    end else if (side == 1) begin
                        dr = near;
                    end else begin
                        dl = near;
                        dr = 10'($urandom_range(32'(tracker.cfg.obstacle_distance_cm) - 1));
                    end
                end else begin
                    dl = 10'($urandom_range(DIST_MAX, 32'(tracker.cfg.obstacle_distance_cm)));
                    dr = 10'($urandom_range(DIST_MAX, 32'(tracker.cfg.obstacle_distance_cm)));
                end
            end
        end

        mission_ms = mission_ms + adv;
        send_tick(make_tick(mission_ms, 1'($urandom), dl, dr, 1'($urandom), 1'($urandom)));
    endtask

    // Celebration ticks: half walk the clock forward by up to twice the swing interval plus
    // two ms, so swings both fire and hold; the rest jump anywhere, wrapping the elapsed time.
    task automatic celeb_ticks(input int unsigned count);
        repeat (count) begin
            if ($urandom_range(1) == 0)
                mission_ms = $urandom;
            else
                mission_ms = mission_ms +
                    $urandom_range(32'(tracker.cfg.celebration_delay_ms) * 2 + 2);
            send_tick(make_tick(mission_ms, 1'($urandom), 10'($urandom), 10'($urandom),
                                1'($urandom), 1'($urandom)));
        end
    endtask

    initial begin
        t_ending ending;

        tracker = new();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- phase 1: sender idles lightly, receiver stalls heavily ----
        send_idle_pct = 38;
        recv_idle_pct = 62;
        write_reg(CFG_START_DELAY, 20'd20, 1'b0);
        write_reg(CFG_STOP_TIME, TIME_MAX, 1'b0);
        write_reg(CFG_EDGE_TIME, 20'd2000, 1'b0);
        write_reg(CFG_OBST_DIST, 20'd10, 1'b0);
        write_reg(CFG_CELEB_DELAY, 20'd500, 1'b0);
        write_reg(CFG_CELEB_ANGLE, 20'd45, 1'b1);

        // Waiting for the start pull: lamp on, sensors at their extremes, clock just short
        // of the stop time.
        send_tick(make_tick(32'd0, 1'b0, '0, DIST_MAX, 1'b1, 1'b0));
        send_tick(make_tick(32'(TIME_MAX) - 32'd1, 1'b0, DIST_MAX, '0, 1'b0, 1'b1));
        send_tick(make_tick(PULL_STAMP, 1'b1, 10'd500, 10'd500, 1'b0, 1'b0));
        // start delay: hold below it, advance exactly at it
        send_tick(make_tick(PULL_STAMP + 32'd10, 1'b0, 10'd500, 10'd500, 1'b0, 1'b0));
        send_tick(make_tick(PULL_STAMP + 32'd19, 1'b1, 10'd500, 10'd500, 1'b1, 1'b1));
        send_tick(make_tick(PULL_STAMP + 32'd20, 1'b0, 10'd500, 10'd500, 1'b0, 1'b0));
        // obstacle left, then right while still avoiding; then a road exactly at threshold
        send_tick(make_tick(PULL_STAMP + 32'd30, 1'b0, 10'd9, DIST_MAX, 1'b0, 1'b0));
        send_tick(make_tick(PULL_STAMP + 32'd31, 1'b0, DIST_MAX, DIST_MAX, 1'b0, 1'b0));
        send_tick(make_tick(PULL_STAMP + 32'd40, 1'b0, DIST_MAX, 10'd9, 1'b0, 1'b0));
        send_tick(make_tick(PULL_STAMP + 32'd41, 1'b0, DIST_MAX, DIST_MAX, 1'b0, 1'b0));
        send_tick(make_tick(PULL_STAMP + 32'd50, 1'b0, 10'd10, 10'd10, 1'b0, 1'b0));
        // every line-sensor pattern while following, a check between each
        send_tick(make_tick(PULL_STAMP + 32'd60, 1'b0, DIST_MAX, DIST_MAX, 1'b0, 1'b0));
        send_tick(make_tick(PULL_STAMP + 32'd61, 1'b0, DIST_MAX, DIST_MAX, 1'b0, 1'b0));
        send_tick(make_tick(PULL_STAMP + 32'd62, 1'b0, DIST_MAX, DIST_MAX, 1'b0, 1'b1));
        send_tick(make_tick(PULL_STAMP + 32'd63, 1'b0, DIST_MAX, DIST_MAX, 1'b0, 1'b0));
        send_tick(make_tick(PULL_STAMP + 32'd64, 1'b0, DIST_MAX, DIST_MAX, 1'b1, 1'b0));
        send_tick(make_tick(PULL_STAMP + 32'd65, 1'b0, DIST_MAX, DIST_MAX, 1'b0, 1'b0));
        send_tick(make_tick(PULL_STAMP + 32'd66, 1'b0, DIST_MAX, DIST_MAX, 1'b1, 1'b1));
        // slow turn: one millisecond short of 0.45 of the edge time, then exactly on it
        // (20 ms start delay and 20 ms behind obstacles are not counted)
        send_tick(make_tick(PULL_STAMP + 32'd938, 1'b0, DIST_MAX, DIST_MAX, 1'b0, 1'b0));
        send_tick(make_tick(PULL_STAMP + 32'd939, 1'b0, DIST_MAX, DIST_MAX, 1'b0, 1'b0));
        send_tick(make_tick(PULL_STAMP + 32'd940, 1'b0, DIST_MAX, DIST_MAX, 1'b0, 1'b0));
        send_tick(make_tick(PULL_STAMP + 32'd940, 1'b0, DIST_MAX, DIST_MAX, 1'b0, 1'b1));
        mission_ms = PULL_STAMP + 32'd940;

        repeat (150) mission_tick();
        drain();

        // ---- phase 2: roles swapped; widest edge time, obstacles almost everywhere ----
        send_idle_pct = 62;
        recv_idle_pct = 38;
        write_reg(CFG_EDGE_TIME, TIME_MAX, 1'b0);
        write_reg(CFG_OBST_DIST, 20'(DIST_MAX), 1'b1);
        repeat (160) mission_tick();
        drain();

        // ---- phase 3: no idling; no obstacle can trigger ----
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_EDGE_TIME, 20'd30000, 1'b0);
        write_reg(CFG_OBST_DIST, 20'd0, 1'b1);
        repeat (100) mission_tick();

        // End the mission: at the edge time exactly, on a time stamp earlier than the start
        // delay, or at or one millisecond past the global stop time from whatever state the mission is in.
        ending = t_ending'($urandom_range(2));
        if (ending != END_GLOBAL) begin
            while (tracker.mode != MODE_FOLLOW)
                mission_tick();
        end
        case (ending)
            END_EDGE:
                mission_ms = tracker.start_stamp + 32'(tracker.cfg.start_delay_ms) +
                             tracker.obstacle_total + 32'(tracker.cfg.edge_stop_time_ms);
            END_EARLY:
                mission_ms = tracker.start_stamp +
                             $urandom_range(32'(tracker.cfg.start_delay_ms) - 1);
            default:
                mission_ms = tracker.start_stamp + 32'(tracker.cfg.stop_time_ms) +
                             $urandom_range(1);
        endcase
        send_tick(make_tick(mission_ms, 1'($urandom), 10'($urandom), 10'($urandom),
                            1'($urandom), 1'($urandom)));
        drain();

        // ---- celebration under several register settings ----
        write_reg(CFG_CELEB_DELAY, 20'd0, 1'b0);
        write_reg(CFG_CELEB_ANGLE, 20'd0, 1'b0);
        write_reg(CFG_START_DELAY, 20'd0, 1'b1);
        celeb_ticks(55);
        drain();

        // widest interval, angle beyond ninety saturates
        write_reg(CFG_CELEB_DELAY, 20'hFFFF, 1'b0);
        write_reg(CFG_CELEB_ANGLE, 20'h7F, 1'b0);
        write_reg(CFG_START_DELAY, TIME_MAX, 1'b0);
        write_reg(CFG_STOP_TIME, 20'd0, 1'b1);
        celeb_ticks(55);
        drain();

        write_reg(CFG_CELEB_DELAY, 20'($urandom_range(40)), 1'b0);
        write_reg(CFG_CELEB_ANGLE, 20'(ANGLE_MAX), 1'b0);
        write_reg(CFG_EDGE_TIME, 20'd0, 1'b0);
        write_reg(CFG_OBST_DIST, 20'($urandom), 1'b1);
        celeb_ticks(55);
        drain();

        // junk in the unused upper bits and spare indexes must change nothing
        write_reg(CFG_CELEB_DELAY, {4'($urandom), 16'($urandom_range(30))}, 1'b0);
        write_reg(CFG_CELEB_ANGLE, {13'($urandom), 7'(ANGLE_MAX + 7'd1)}, 1'b0);
        write_reg(CFG_SPARE_LO, 20'($urandom), 1'b0);
        write_reg(CFG_SPARE_HI, 20'($urandom), 1'b0);
        write_reg(CFG_STOP_TIME, 20'($urandom), 1'b1);
        celeb_ticks(55);
        drain();

        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/lrms_pkg.sv
hw/rtl/lrms_cfg.sv
hw/rtl/lrms_core.sv
hw/rtl/line_robot_mission_sequencer_unit.sv
hw/rtl/lrms_chk.sv
tb/mission_check_pkg.sv
tb/tb_top.sv
